[sv/nfi_pkg.sv]
package nfi_pkg;

  // transaction kinds on the cmd port
  localparam logic [1:0] CMD_BUS_READ  = 2'd0;
  localparam logic [1:0] CMD_BUS_WRITE = 2'd1;
  localparam logic [1:0] CMD_PRELOAD   = 2'd2;

  // register window offsets
  localparam logic [2:0] OFS_DATA = 3'd0;
  localparam logic [2:0] OFS_CMD  = 3'd4;
  localparam logic [2:0] OFS_ADDR = 3'd6;

  // flash commands held in the command latch
  localparam logic [31:0] FCMD_READ     = 32'h0000_0000;
  localparam logic [31:0] FCMD_READ_OOB = 32'h0000_0050;
  localparam logic [31:0] FCMD_READ_ID  = 32'h0000_0090;

  // bus lane masks
  localparam logic [31:0] MASK_WORD = 32'hffff_ffff;
  localparam logic [31:0] MASK_BYTE = 32'h0000_00ff;

  // fixed read values
  localparam logic [31:0] OOB_FILL  = 32'h0000_00ff;
  localparam logic [31:0] ID_MAKER  = 32'h0000_00ec;
  localparam logic [31:0] ID_DEVICE = 32'h0000_0076;

  localparam logic [2:0] STAGE_MAX   = 3'd7;
  localparam logic [2:0] ADDR_BYTES  = 3'd4;
  localparam logic [2:0] ADDR_LAST   = 3'd3;
  localparam logic [1:0] LANE_LAST   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } nfi_state_t;

endpackage

[sv/nfi_flash_mem.sv]
module nfi_flash_mem import nfi_pkg::*; #(
  parameter int FLASH_INDEX_BITS = 21
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [FLASH_INDEX_BITS-1:0] wr_addr,
  input  logic [31:0]                 wr_data,
  input  logic                        rd_en,
  input  logic [FLASH_INDEX_BITS-1:0] rd_addr,
  output logic [31:0]                 rd_data
);

  localparam int DEPTH = 1 << FLASH_INDEX_BITS;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/nand_flash_read_interface.sv]
// NAND flash bus interface. One transaction is taken when start is high and
// busy is low. The flash word at the current word pointer is read from the
// store's synchronous port on the accepting edge, and in the following cycle
// done pulses for one cycle with read_data (zero for writes and preloads)
// while the window registers update. busy is high during that response
// cycle, so a new transaction cannot be taken until the last one has been
// answered. The receiver cannot stall: read_data is valid only in the cycle
// done is high. A preload (cmd 2) writes one flash word at load_index
// modulo the store size. Flash words never preloaded read back as unknown
// values. Reset clears the command latch, stage counters, address assembly
// and word pointer, but not the flash store; there is no clearing pass.
module nand_flash_read_interface import nfi_pkg::*; #(
  parameter int FLASH_INDEX_BITS = 21
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [2:0]  offset,
  input  logic [31:0] data,
  input  logic [31:0] lane_mask,
  input  logic [20:0] load_index,
  output logic        done,
  output logic [31:0] read_data
);

  nfi_state_t state, state_next;

  logic accept;

  // captured transaction
  logic [1:0]  cmd_q;
  logic [2:0]  offset_q;
  logic [31:0] data_q;
  logic [31:0] mask_q;

  // window state
  logic [31:0] command_latch, command_latch_next;
  logic [2:0]  sequence_stage, sequence_stage_next;
  logic [1:0]  byte_stage, byte_stage_next;
  logic [31:0] address_assembly, address_assembly_next;
  logic [31:0] word_pointer, word_pointer_next;

  logic [31:0] result;
  logic [31:0] flash_word;
  logic [31:0] load_ext;
  logic [31:0] lane_sel;
  logic [2:0]  stage_inc;

  assign accept   = start && !busy;
  assign load_ext = {11'b0, load_index};

  // flash store: preload writes and pointer reads both land on the accept
  // edge; the pointer cannot change before the read is consumed
  nfi_flash_mem #(
    .FLASH_INDEX_BITS(FLASH_INDEX_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (accept && (cmd == CMD_PRELOAD)),
    .wr_addr(load_ext[FLASH_INDEX_BITS-1:0]),
    .wr_data(data),
    .rd_en  (accept),
    .rd_addr(word_pointer[FLASH_INDEX_BITS-1:0]),
    .rd_data(flash_word)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd;
      offset_q <= offset;
      data_q   <= data;
      mask_q   <= lane_mask;
    end
  end

  // state machine: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    busy = 1'b0;
    done = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_RESP: begin
        busy = 1'b1;
        done = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // transaction execution in the response cycle
  assign stage_inc = (sequence_stage < STAGE_MAX) ? sequence_stage + 3'd1 : sequence_stage;
  assign lane_sel  = MASK_BYTE << {sequence_stage[1:0], 3'b000};

  always_comb begin
    result                = '0;
    command_latch_next    = command_latch;
    sequence_stage_next   = sequence_stage;
    byte_stage_next       = byte_stage;
    address_assembly_next = address_assembly;
    word_pointer_next     = word_pointer;
    if (state == ST_RESP) begin
      case (cmd_q)
        CMD_BUS_READ: begin
          if (offset_q == OFS_DATA) begin
            if (command_latch == FCMD_READ) begin
              if (mask_q == MASK_WORD) begin
                result            = flash_word;
                word_pointer_next = word_pointer + 32'd1;
              end else if (mask_q == MASK_BYTE) begin
                // upper bytes are not masked off
                result          = flash_word >> {byte_stage, 3'b000};
                byte_stage_next = byte_stage + 2'd1;
                if (byte_stage == LANE_LAST) begin
                  word_pointer_next = word_pointer + 32'd1;
                end
              end
            end else if (command_latch == FCMD_READ_OOB) begin
              result = OOB_FILL;
            end else if (command_latch == FCMD_READ_ID) begin
              sequence_stage_next = stage_inc;
              if (sequence_stage == 3'd0) begin
                result = ID_MAKER;
              end else if (sequence_stage == 3'd1) begin
                result = ID_DEVICE;
              end
            end
          end
        end
        CMD_BUS_WRITE: begin
          if (offset_q == OFS_CMD) begin
            command_latch_next  = data_q;
            sequence_stage_next = '0;
            byte_stage_next     = '0;
          end else if (offset_q == OFS_ADDR && command_latch == FCMD_READ) begin
            if (sequence_stage < ADDR_BYTES) begin
              address_assembly_next = (address_assembly & ~lane_sel)
                                    | ({24'b0, data_q[7:0]} << {sequence_stage[1:0], 3'b000});
              if (sequence_stage == ADDR_LAST) begin
                // pointer counts 16-bit bus words as flash words
                word_pointer_next = {1'b0, address_assembly_next[31:1]};
              end
            end
            sequence_stage_next = stage_inc;
          end
        end
        default: result = '0;
      endcase
    end
  end

  assign read_data = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_latch    <= '0;
      sequence_stage   <= '0;
      byte_stage       <= '0;
      address_assembly <= '0;
      word_pointer     <= '0;
    end else begin
      command_latch    <= command_latch_next;
      sequence_stage   <= sequence_stage_next;
      byte_stage       <= byte_stage_next;
      address_assembly <= address_assembly_next;
      word_pointer     <= word_pointer_next;
    end
  end

endmodule
